/* rtl/bca_pkg.sv */
// Shared constants, word types and small encoder functions for the buddy chunk allocator.
// No dependencies; every other file in rtl/ imports this package.
package bca_pkg;

    localparam int POOL_BITS = 20;
    localparam int MIN_CLASS = 6;
    localparam int MAX_CLASS = 20;

    localparam int SLOT_W  = POOL_BITS - MIN_CLASS;
    localparam int SLOTS   = 1 << SLOT_W;
    localparam int LINK_W  = SLOT_W + 1;
    localparam int NCLASS  = MAX_CLASS - MIN_CLASS + 1;
    localparam int CIDX_W  = $clog2(NCLASS);
    localparam int CLS_W   = 5;
    localparam int ACT_W   = 2;
    localparam int SIZE_W  = 21;
    localparam int OFS_W   = 20;
    localparam int ST_W    = 2;
    localparam int POOL_W  = 15;
    localparam int START_W = 14;
    localparam int SUM_W   = SIZE_W + 1;
    localparam int HDR_BYTES = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = POOL_W;

    localparam logic [LINK_W-1:0] LINK_END = LINK_W'(SLOTS);

    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REINIT  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK          = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_FREE     = 2'd1;
    localparam logic [ST_W-1:0] ST_TOO_LARGE   = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD_RELEASE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_SLOTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_SLOT = 2'd1;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [SIZE_W-1:0] request_size;
        logic [OFS_W-1:0]  release_offset;
    } in_item_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [OFS_W-1:0] data_offset;
        logic [CLS_W-1:0] chunk_class;
    } out_item_t;

    typedef struct packed {
        logic [POOL_W-1:0]  pool_slots;
        logic [START_W-1:0] start_slot;
    } cfg_t;

    typedef struct packed {
        logic             active;
        logic [CLS_W-1:0] cls;
    } info_t;

    typedef struct packed {
        logic [LINK_W-1:0] nxt;
        logic [LINK_W-1:0] prv;
    } link_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } mem_rd_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        info_t             data;
    } info_wr_t;

    typedef struct packed {
        logic              en_nxt;
        logic              en_prv;
        logic [SLOT_W-1:0] addr;
        link_t             data;
    } link_wr_t;

    // index of highest set bit plus one, zero for zero
    function automatic logic [CLS_W-1:0] bit_len(input logic [SUM_W-1:0] v);
        logic [CLS_W-1:0] r;
        r = '0;
        for (int i = 0; i < SUM_W; i++) begin
            if (v[i]) begin
                r = CLS_W'(i + 1);
            end
        end
        return r;
    endfunction

    function automatic logic [CLS_W-1:0] floor_log2(input logic [LINK_W-1:0] v);
        logic [CLS_W-1:0] r;
        r = '0;
        for (int i = 0; i < LINK_W; i++) begin
            if (v[i]) begin
                r = CLS_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [CLS_W-1:0] trail_zeros(input logic [LINK_W-1:0] v);
        logic [CLS_W-1:0] r;
        r = '0;
        for (int i = LINK_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = CLS_W'(i);
            end
        end
        return r;
    endfunction

endpackage

/* rtl/buddy_chunk_allocator.sv */
// Top level of the buddy chunk allocator: configuration registers, sequencer, slot memories.
// Depends on bca_pkg, bca_ctrl, bca_info_ram and bca_link_ram.
//
// Usage:
//   s_ channel takes one command word: allocate, release or reinitialize the pool.
//   m_ channel returns exactly one result word per command (status, offset, class).
//   cfg_ channel writes pool_slots (index 0) or start_slot (index 1); write only when idle.
// Operation: one command at a time; free-list heads are registers, per-slot state sits in two
//   slot memories with one write port and one registered read port each.
//   allocate:   takes the list head and splits once per level above the requested class.
//   release:    checks the chunk, merges with a free buddy once per level, then pushes it.
//   reinit:     clearing pass over the info memory, then carves aligned chunks onto the lists.
//   Release of a non-active chunk, other failures and unknown actions go straight to the result.
// Reset: all free lists empty, registers at pool_slots 16384 and start_slot 32; the slot
//   memories are not cleared, so issue a reinitialize before the first allocate or release.
// Stall: the result sits in an output register; the next command is accepted meanwhile, and
//   the sequencer holds its next result until the current word is taken.
module buddy_chunk_allocator import bca_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    logic [POOL_W-1:0]  pool_slots_reg, pool_slots_next;
    logic [START_W-1:0] start_slot_reg, start_slot_next;
    cfg_t               cfg;
    mem_rd_t            info_rd;
    info_t              info_q;
    info_wr_t           info_wr;
    mem_rd_t            link_rd;
    link_t              link_q;
    link_wr_t           link_wr;

    assign cfg_ready = 1'b1;

    always_comb begin
        pool_slots_next = pool_slots_reg;
        start_slot_next = start_slot_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_POOL_SLOTS: pool_slots_next = cfg_data[POOL_W-1:0];
                REG_START_SLOT: start_slot_next = cfg_data[START_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_slots_reg <= POOL_W'(16384);
            start_slot_reg <= START_W'(32);
        end else begin
            pool_slots_reg <= pool_slots_next;
            start_slot_reg <= start_slot_next;
        end
    end

    assign cfg.pool_slots = pool_slots_reg;
    assign cfg.start_slot = start_slot_reg;

    bca_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .info_rd (info_rd),
        .info_q  (info_q),
        .info_wr (info_wr),
        .link_rd (link_rd),
        .link_q  (link_q),
        .link_wr (link_wr)
    );

    bca_info_ram u_info_ram (
        .aclk (aclk),
        .rd   (info_rd),
        .rd_q (info_q),
        .wr   (info_wr)
    );

    bca_link_ram u_link_ram (
        .aclk (aclk),
        .rd   (link_rd),
        .rd_q (link_q),
        .wr   (link_wr)
    );

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.data_offset == '0
            && m_data.chunk_class == '0)
        else $error("failed result carries offset or class");

    a_grant_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_OK && m_data.data_offset != '0
            |-> m_data.data_offset[MIN_CLASS-1:0] == MIN_CLASS'(HDR_BYTES)
            && m_data.chunk_class >= CLS_W'(MIN_CLASS)
            && m_data.chunk_class <= CLS_W'(MAX_CLASS))
        else $error("granted chunk misaligned or class out of range");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("command accepted while previous one in flight");

endmodule

/* rtl/bca_info_ram.sv */
// Per-slot info memory: active mark and class, one write and one registered read per cycle.
// Depends on bca_pkg.
module bca_info_ram import bca_pkg::*; (
    input  logic     aclk,
    input  mem_rd_t  rd,
    output info_t    rd_q,
    input  info_wr_t wr
);

    info_t mem [SLOTS];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rd_q <= mem[rd.addr];
        end
    end

endmodule

/* rtl/bca_link_ram.sv */
// Per-slot free-list link memory with separate write enables for next and prev fields.
// Depends on bca_pkg.
module bca_link_ram import bca_pkg::*; (
    input  logic     aclk,
    input  mem_rd_t  rd,
    output link_t    rd_q,
    input  link_wr_t wr
);

    link_t mem [SLOTS];

    always_ff @(posedge aclk) begin
        if (wr.en_nxt) begin
            mem[wr.addr].nxt <= wr.data.nxt;
        end
        if (wr.en_prv) begin
            mem[wr.addr].prv <= wr.data.prv;
        end
        if (rd.en) begin
            rd_q <= mem[rd.addr];
        end
    end

endmodule

/* rtl/bca_ctrl.sv */
// Sequencer for allocate, release and reinit: list heads, list/merge/split walks, result word.
// Depends on bca_pkg; drives bca_info_ram and bca_link_ram.
module bca_ctrl import bca_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    output mem_rd_t   info_rd,
    input  info_t     info_q,
    output info_wr_t  info_wr,
    output mem_rd_t   link_rd,
    input  link_t     link_q,
    output link_wr_t  link_wr
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE,
        S_SPLIT_RD, S_SPLIT_INFO, S_SPLIT_INFO2, S_SPLIT_PUSH2, S_SPLIT_NEXT,
        S_TAKE_RD, S_TAKE_DONE,
        S_REL_CHK, S_MERGE_CK, S_MERGE_RD, S_MERGE_UP, S_REL_PUSH, S_REL_DONE,
        S_CLEAR, S_CARVE, S_CARVE_NEXT,
        S_RM_RD, S_RM_P, S_RM_N, S_PU_A, S_PU_B,
        S_FINISH
    } state_t;

    state_t            state_reg, state_next;
    state_t            ret_reg, ret_next;
    in_item_t          item_reg, item_next;
    logic [LINK_W-1:0] s_reg, s_next;
    logic [SLOT_W-1:0] up_reg, up_next;
    logic [CLS_W-1:0]  cls_reg, cls_next;
    logic [CLS_W-1:0]  j_reg, j_next;
    logic [SLOT_W-1:0] rm_slot_reg, rm_slot_next;
    logic [CIDX_W-1:0] rm_cls_reg, rm_cls_next;
    logic [LINK_W-1:0] p_reg, p_next;
    logic [LINK_W-1:0] n_reg, n_next;
    logic [SLOT_W-1:0] pu_slot_reg, pu_slot_next;
    logic [CIDX_W-1:0] pu_cls_reg, pu_cls_next;
    logic [LINK_W-1:0] h_reg, h_next;
    logic [LINK_W-1:0] head_reg [NCLASS];
    logic [LINK_W-1:0] head_next [NCLASS];
    logic [SLOT_W-1:0] clr_reg, clr_next;
    logic [LINK_W-1:0] size_reg, size_next;
    out_item_t         res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    logic [LINK_W-1:0] lim;
    logic [SLOT_W-1:0] s14;
    logic [CIDX_W-1:0] hd_idx;
    logic [LINK_W-1:0] hd;
    logic [SUM_W-1:0]  sum_v;
    logic [CLS_W-1:0]  blen;
    logic [CLS_W-1:0]  req_cls;
    logic [CIDX_W-1:0] req_idx;
    logic              too_big;
    logic              found;
    logic [CIDX_W-1:0] k_idx;
    logic [CLS_W-1:0]  k_cls;
    logic [OFS_W-1:0]  rel_start;
    logic [SLOT_W-1:0] rel_slot;
    logic              rel_bad;
    logic [SLOT_W-1:0] m_size;
    logic [SLOT_W-1:0] buddy;
    logic              buddy_out;
    logic [SLOT_W-1:0] m_base;
    logic [SLOT_W-1:0] half;
    logic [SLOT_W:0]   up_sum;
    logic [SLOT_W-1:0] up_slot;
    logic [CLS_W-1:0]  c_tz;
    logic [CLS_W-1:0]  c_fl;
    logic [CLS_W-1:0]  c_off;

    assign lim = (cfg.pool_slots > POOL_W'(SLOTS)) ? LINK_W'(SLOTS) : LINK_W'(cfg.pool_slots);
    assign s14 = s_reg[SLOT_W-1:0];

    always_comb begin
        case (state_reg)
            S_SPLIT_RD: hd_idx = CIDX_W'(j_reg - CLS_W'(MIN_CLASS));
            S_TAKE_RD:  hd_idx = CIDX_W'(cls_reg - CLS_W'(MIN_CLASS));
            default:    hd_idx = pu_cls_reg;
        endcase
    end
    assign hd = head_reg[hd_idx];

    // allocate: size class and first non-empty list at or above it
    assign sum_v   = SUM_W'(item_reg.request_size) + SUM_W'(HDR_BYTES - 1);
    assign blen    = bit_len(sum_v);
    assign too_big = blen > CLS_W'(MAX_CLASS);
    assign req_cls = (blen < CLS_W'(MIN_CLASS)) ? CLS_W'(MIN_CLASS) : blen;
    assign req_idx = CIDX_W'(req_cls - CLS_W'(MIN_CLASS));

    always_comb begin
        found = 1'b0;
        k_idx = '0;
        for (int i = NCLASS - 1; i >= 0; i--) begin
            if (!head_reg[i][LINK_W-1] && CIDX_W'(i) >= req_idx) begin
                found = 1'b1;
                k_idx = CIDX_W'(i);
            end
        end
    end
    assign k_cls = CLS_W'(k_idx) + CLS_W'(MIN_CLASS);

    // release: offset checks
    assign rel_start = item_reg.release_offset - OFS_W'(HDR_BYTES);
    assign rel_slot  = rel_start[OFS_W-1:MIN_CLASS];
    assign rel_bad   = (item_reg.release_offset < OFS_W'(HDR_BYTES))
                     || (rel_start[MIN_CLASS-1:0] != '0)
                     || (LINK_W'(rel_slot) >= lim);

    // merge: buddy of current chunk
    assign m_size    = SLOT_W'(1) << (cls_reg - CLS_W'(MIN_CLASS));
    assign buddy     = s14 ^ m_size;
    assign buddy_out = (LINK_W'(buddy) >= lim) || (buddy < cfg.start_slot);
    assign m_base    = s14 & ~((m_size << 1) - SLOT_W'(1));

    // split: upper half
    assign half    = SLOT_W'(1) << (j_reg - CLS_W'(MIN_CLASS + 1));
    assign up_sum  = (SLOT_W + 1)'(s14) + (SLOT_W + 1)'(half);
    assign up_slot = up_sum[SLOT_W] ? s14 : up_sum[SLOT_W-1:0];

    // carve: largest aligned chunk that fits
    assign c_tz = trail_zeros(s_reg);
    assign c_fl = floor_log2(lim - s_reg);
    always_comb begin
        c_off = c_tz;
        if (c_fl < c_off) begin
            c_off = c_fl;
        end
        if (CLS_W'(MAX_CLASS - MIN_CLASS) < c_off) begin
            c_off = CLS_W'(MAX_CLASS - MIN_CLASS);
        end
    end

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        item_next    = item_reg;
        s_next       = s_reg;
        up_next      = up_reg;
        cls_next     = cls_reg;
        j_next       = j_reg;
        rm_slot_next = rm_slot_reg;
        rm_cls_next  = rm_cls_reg;
        p_next       = p_reg;
        n_next       = n_reg;
        pu_slot_next = pu_slot_reg;
        pu_cls_next  = pu_cls_reg;
        h_next       = h_reg;
        head_next    = head_reg;
        clr_next     = clr_reg;
        size_next    = size_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        info_rd      = '0;
        info_wr      = '0;
        link_rd      = '0;
        link_wr      = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                res_next = '0;
                case (item_reg.action)
                    ACT_ALLOC: begin
                        if (too_big) begin
                            res_next.status = ST_TOO_LARGE;
                            state_next      = S_FINISH;
                        end else if (!found) begin
                            res_next.status = ST_NO_FREE;
                            state_next      = S_FINISH;
                        end else begin
                            cls_next   = req_cls;
                            j_next     = k_cls;
                            state_next = (k_cls > req_cls) ? S_SPLIT_RD : S_TAKE_RD;
                        end
                    end
                    ACT_RELEASE: begin
                        if (rel_bad) begin
                            res_next.status = ST_BAD_RELEASE;
                            state_next      = S_FINISH;
                        end else begin
                            info_rd.en   = 1'b1;
                            info_rd.addr = rel_slot;
                            s_next       = LINK_W'(rel_slot);
                            state_next   = S_REL_CHK;
                        end
                    end
                    ACT_REINIT: begin
                        clr_next = '0;
                        for (int i = 0; i < NCLASS; i++) begin
                            head_next[i] = LINK_END;
                        end
                        state_next = S_CLEAR;
                    end
                    default: begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SPLIT_RD: begin
                s_next       = hd;
                rm_slot_next = hd[SLOT_W-1:0];
                rm_cls_next  = CIDX_W'(j_reg - CLS_W'(MIN_CLASS));
                ret_next     = S_SPLIT_INFO;
                state_next   = S_RM_RD;
            end
            S_SPLIT_INFO: begin
                up_next          = up_slot;
                info_wr.en       = 1'b1;
                info_wr.addr     = s14;
                info_wr.data.cls = j_reg - CLS_W'(1);
                state_next       = S_SPLIT_INFO2;
            end
            S_SPLIT_INFO2: begin
                info_wr.en       = 1'b1;
                info_wr.addr     = up_reg;
                info_wr.data.cls = j_reg - CLS_W'(1);
                pu_slot_next     = s14;
                pu_cls_next      = CIDX_W'(j_reg - CLS_W'(MIN_CLASS + 1));
                ret_next         = S_SPLIT_PUSH2;
                state_next       = S_PU_A;
            end
            S_SPLIT_PUSH2: begin
                pu_slot_next = up_reg;
                ret_next     = S_SPLIT_NEXT;
                state_next   = S_PU_A;
            end
            S_SPLIT_NEXT: begin
                j_next     = j_reg - CLS_W'(1);
                state_next = (j_reg - CLS_W'(1) > cls_reg) ? S_SPLIT_RD : S_TAKE_RD;
            end
            S_TAKE_RD: begin
                s_next       = hd;
                rm_slot_next = hd[SLOT_W-1:0];
                rm_cls_next  = CIDX_W'(cls_reg - CLS_W'(MIN_CLASS));
                ret_next     = S_TAKE_DONE;
                state_next   = S_RM_RD;
            end
            S_TAKE_DONE: begin
                info_wr.en          = 1'b1;
                info_wr.addr        = s14;
                info_wr.data.active = 1'b1;
                info_wr.data.cls    = cls_reg;
                res_next.status      = ST_OK;
                res_next.data_offset = OFS_W'({s14, MIN_CLASS'(0)}) + OFS_W'(HDR_BYTES);
                res_next.chunk_class = cls_reg;
                state_next           = S_FINISH;
            end
            S_REL_CHK: begin
                if (!info_q.active || info_q.cls < CLS_W'(MIN_CLASS)
                        || info_q.cls > CLS_W'(MAX_CLASS)) begin
                    res_next.status = ST_BAD_RELEASE;
                    state_next      = S_FINISH;
                end else begin
                    info_wr.en       = 1'b1;
                    info_wr.addr     = s14;
                    info_wr.data.cls = info_q.cls;
                    cls_next         = info_q.cls;
                    state_next       = S_MERGE_CK;
                end
            end
            S_MERGE_CK: begin
                if (cls_reg == CLS_W'(MAX_CLASS) || buddy_out) begin
                    state_next = S_REL_PUSH;
                end else begin
                    info_rd.en   = 1'b1;
                    info_rd.addr = buddy;
                    up_next      = buddy;
                    state_next   = S_MERGE_RD;
                end
            end
            S_MERGE_RD: begin
                if (info_q.active || info_q.cls != cls_reg) begin
                    state_next = S_REL_PUSH;
                end else begin
                    rm_slot_next = up_reg;
                    rm_cls_next  = CIDX_W'(cls_reg - CLS_W'(MIN_CLASS));
                    ret_next     = S_MERGE_UP;
                    state_next   = S_RM_RD;
                end
            end
            S_MERGE_UP: begin
                cls_next         = cls_reg + CLS_W'(1);
                s_next           = LINK_W'(m_base);
                info_wr.en       = 1'b1;
                info_wr.addr     = m_base;
                info_wr.data.cls = cls_reg + CLS_W'(1);
                state_next       = S_MERGE_CK;
            end
            S_REL_PUSH: begin
                pu_slot_next = s14;
                pu_cls_next  = CIDX_W'(cls_reg - CLS_W'(MIN_CLASS));
                ret_next     = S_REL_DONE;
                state_next   = S_PU_A;
            end
            S_REL_DONE: begin
                res_next.status      = ST_OK;
                res_next.chunk_class = cls_reg;
                state_next           = S_FINISH;
            end
            S_CLEAR: begin
                info_wr.en   = 1'b1;
                info_wr.addr = clr_reg;
                clr_next     = clr_reg + SLOT_W'(1);
                if (clr_reg == SLOT_W'(SLOTS - 1)) begin
                    s_next     = (cfg.start_slot == '0) ? LINK_W'(1) : LINK_W'(cfg.start_slot);
                    state_next = S_CARVE;
                end
            end
            S_CARVE: begin
                if (s_reg >= lim) begin
                    state_next = S_FINISH;
                end else begin
                    info_wr.en       = 1'b1;
                    info_wr.addr     = s14;
                    info_wr.data.cls = c_off + CLS_W'(MIN_CLASS);
                    size_next        = LINK_W'(1) << c_off;
                    pu_slot_next     = s14;
                    pu_cls_next      = CIDX_W'(c_off);
                    ret_next         = S_CARVE_NEXT;
                    state_next       = S_PU_A;
                end
            end
            S_CARVE_NEXT: begin
                s_next     = s_reg + size_reg;
                state_next = S_CARVE;
            end
            S_RM_RD: begin
                link_rd.en   = 1'b1;
                link_rd.addr = rm_slot_reg;
                state_next   = S_RM_P;
            end
            S_RM_P: begin
                p_next = link_q.prv;
                n_next = link_q.nxt;
                if (!link_q.prv[LINK_W-1]) begin
                    link_wr.en_nxt   = 1'b1;
                    link_wr.addr     = link_q.prv[SLOT_W-1:0];
                    link_wr.data.nxt = link_q.nxt;
                end else begin
                    head_next[rm_cls_reg] = link_q.nxt;
                end
                state_next = S_RM_N;
            end
            S_RM_N: begin
                if (!n_reg[LINK_W-1]) begin
                    link_wr.en_prv   = 1'b1;
                    link_wr.addr     = n_reg[SLOT_W-1:0];
                    link_wr.data.prv = p_reg;
                end
                state_next = ret_reg;
            end
            S_PU_A: begin
                h_next                = hd;
                link_wr.en_nxt        = 1'b1;
                link_wr.en_prv        = 1'b1;
                link_wr.addr          = pu_slot_reg;
                link_wr.data.nxt      = hd;
                link_wr.data.prv      = LINK_END;
                head_next[pu_cls_reg] = LINK_W'(pu_slot_reg);
                state_next            = S_PU_B;
            end
            S_PU_B: begin
                if (!h_reg[LINK_W-1]) begin
                    link_wr.en_prv   = 1'b1;
                    link_wr.addr     = h_reg[SLOT_W-1:0];
                    link_wr.data.prv = LINK_W'(pu_slot_reg);
                end
                state_next = ret_reg;
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NCLASS; i++) begin
                head_reg[i] <= LINK_END;
            end
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            m_valid_reg <= m_valid_next;
            head_reg    <= head_next;
        end
        item_reg    <= item_next;
        s_reg       <= s_next;
        up_reg      <= up_next;
        cls_reg     <= cls_next;
        j_reg       <= j_next;
        rm_slot_reg <= rm_slot_next;
        rm_cls_reg  <= rm_cls_next;
        p_reg       <= p_next;
        n_reg       <= n_next;
        pu_slot_reg <= pu_slot_next;
        pu_cls_reg  <= pu_cls_next;
        h_reg       <= h_next;
        clr_reg     <= clr_next;
        size_reg    <= size_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
